/* src/bkw_pkg.sv */
// Package for the boundary kernel weight evaluator: fixed-point format, kernel
// descriptors, coefficient rows and the product rounding function.
// No dependencies.
`default_nettype none

package bkw_pkg;

    localparam int FracBits = 16;
    localparam int One      = 1 << FracBits;

    typedef struct packed {
        logic signed [28:0] factor;
        logic [1:0]         qu_pow;
        logic [2:0]         up_pow;
        logic [4:0]         den_pow;
    } t_kern;

    typedef struct packed {
        logic neg;
        logic over;
    } t_div_tag;

    function automatic logic [127:0] pk(input int c0, input int c1, input int c2,
                                        input int c3, input int c4, input int c5,
                                        input int c6);
        return {16'd0, 16'(c6), 16'(c5), 16'(c4), 16'(c3), 16'(c2), 16'(c1), 16'(c0)};
    endfunction

    localparam logic [127:0] CoefRows [60] = '{
        pk(2, -2, 2, 0, 0, 0, 0), pk(3, -3, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(1, -2, 3, 0, 0, 0, 0), pk(2, -4, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(1, -2, 2, 0, 0, 0, 0), pk(2, -3, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(3, -16, 39, -30, 10, 0, 0), pk(14, -63, 84, -35, 0, 0, 0),
        pk(14, -56, 28, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(2, -9, 12, -5, 0, 0, 0), pk(11, -26, 19, 0, 0, 0, 0),
        pk(12, -16, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(1, -10, 45, -84, 77, -30, 5), pk(8, -70, 216, -280, 152, -30, 0),
        pk(18, -144, 300, -240, 54, 0, 0), pk(12, -90, 120, -30, 0, 0, 0),
        pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(4, -35, 108, -140, 76, -15, 0), pk(37, -212, 444, -344, 97, 0, 0),
        pk(90, -381, 480, -183, 0, 0, 0), pk(63, -210, 105, 0, 0, 0, 0),
        pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(3, -24, 50, -40, 9, 0, 0), pk(30, -127, 160, -61, 0, 0, 0),
        pk(77, -182, 119, 0, 0, 0, 0), pk(56, -70, 0, 0, 0, 0, 0),
        pk(0, 0, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(6, -60, 175, -210, 105, -16, 0), pk(78, -478, 903, -672, 157, 0, 0),
        pk(315, -1200, 1407, -510, 0, 0, 0), pk(495, -1122, 671, 0, 0, 0, 0),
        pk(264, -308, 0, 0, 0, 0, 0), pk(0, 0, 0, 0, 0, 0, 0),
        pk(10, -120, 459, -768, 612, -216, 25), pk(160, -1293, 3420, -3912, 1944, -321, 0),
        pk(884, -4836, 8658, -6240, 1482, 0, 0), pk(2184, -7878, 8892, -3146, 0, 0, 0),
        pk(2470, -5460, 3120, 0, 0, 0, 0), pk(1040, -1170, 0, 0, 0, 0, 0)
    };

    function automatic logic signed [15:0] coef(input logic [3:0] sel, input logic [2:0] j,
                                                input logic [2:0] i);
        logic [127:0] row;
        row = '0;
        if (sel <= 4'd9 && j <= 3'd5) begin
            row = CoefRows[6'(int'(sel) * 6 + int'(j))];
        end
        return row[16 * i +: 16];
    endfunction

    function automatic t_kern kern_info(input logic [3:0] sel);
        t_kern k;
        k = '0;
        case (sel)
            4'd0: k = '{29'sd2, 2'd0, 3'd0, 5'd3};
            4'd1: k = '{29'sd6, 2'd0, 3'd1, 5'd4};
            4'd2: k = '{29'sd60, 2'd1, 3'd2, 5'd6};
            4'd3: k = '{29'sd60, 2'd1, 3'd2, 5'd8};
            4'd4: k = '{-29'sd420, 2'd1, 3'd2, 5'd8};
            4'd5: k = '{29'sd420, 2'd1, 3'd2, 5'd10};
            4'd6: k = '{-29'sd840, 2'd1, 3'd2, 5'd10};
            4'd7: k = '{29'sd5040, 2'd1, 3'd2, 5'd10};
            4'd8: k = '{-29'sd720720, 2'd2, 3'd3, 5'd14};
            4'd9: k = '{29'sd147026880, 2'd3, 3'd4, 5'd18};
            default: k = '0;
        endcase
        return k;
    endfunction

    // round a product to FracBits fraction bits, ties away from zero
    function automatic logic signed [63:0] fx_rnd(input logic signed [79:0] p);
        logic signed [79:0] t;
        t = p + (80'sd1 <<< (FracBits - 1));
        if (p[79]) begin
            t = t - 80'sd1;
        end
        return t[FracBits +: 64];
    endfunction

endpackage

`default_nettype wire

/* src/bkw_div.sv */
// Pipelined restoring divider, one quotient bit per stage, 48 stages.
// Depends on bkw_pkg for the sideband tag type.
`default_nettype none

module bkw_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [45:0]       i_rem,
    input  wire logic [47:0]       i_num,
    input  wire logic [45:0]       i_den,
    input  wire bkw_pkg::t_div_tag i_tag,
    output logic                   o_valid,
    output logic [47:0]            o_quo,
    output logic [45:0]            o_rem,
    output bkw_pkg::t_div_tag      o_tag
);

    logic [47:0]       r_vld;
    logic [45:0]       r_rem [48];
    logic [47:0]       r_num [48];
    logic [47:0]       r_quo [48];
    bkw_pkg::t_div_tag r_tag [48];

    logic [46:0]       n_step [48];

    function automatic logic [46:0] div_bit(input logic [45:0] rem, input logic nb,
                                            input logic [45:0] den);
        logic [46:0] t;
        logic        ge;
        t  = {rem, nb};
        ge = t >= {1'b0, den};
        return {ge, ge ? 46'(t - {1'b0, den}) : t[45:0]};
    endfunction

    always_comb begin
        n_step[0] = div_bit(i_rem, i_num[47], i_den);
        for (int k = 1; k < 48; k++) begin
            n_step[k] = div_bit(r_rem[k - 1], r_num[k - 1][47], i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[46:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_step[0][45:0];
            r_num[0] <= {i_num[46:0], 1'b0};
            r_quo[0] <= {47'd0, n_step[0][46]};
            r_tag[0] <= i_tag;
            for (int k = 1; k < 48; k++) begin
                r_rem[k] <= n_step[k][45:0];
                r_num[k] <= {r_num[k - 1][46:0], 1'b0};
                r_quo[k] <= {r_quo[k - 1][46:0], n_step[k][46]};
                r_tag[k] <= r_tag[k - 1];
            end
        end
    end

    assign o_valid = r_vld[47];
    assign o_quo   = r_quo[47];
    assign o_rem   = r_rem[47];
    assign o_tag   = r_tag[47];

endmodule

`default_nettype wire

/* src/boundary_kernel_weight_eval_top.sv */
// Boundary-corrected smoothing kernel weight evaluator, top level.
// Depends on bkw_pkg and bkw_div.
//
// Takes one position per cycle while o_ready is high and returns its weight
// through one input register, twelve multiply stages (five Horner steps in u,
// three boundary factors, four end factors), two stages for the kernel factor
// product and 48 divider stages, one quotient bit each, then the output register.
// After reset and after every register write a shared multiplier evaluates the
// q-dependent coefficients and then the denominator, a power of (1 + q) given by
// the denominator power of the selected kernel; no item is accepted meanwhile.
`default_nettype none

module boundary_kernel_weight_eval_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [17:0] i_position,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [47:0]      o_weight,
    output logic                    o_saturated,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic RegKernel = 1'b0;
    localparam logic RegQ      = 1'b1;
    localparam logic signed [47:0] SatMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SatMin = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {SEQ_COEF, SEQ_DEN, SEQ_DONE} t_seq;

    logic [3:0]  r_sel;
    logic [16:0] r_q;
    logic        w_wr;

    t_seq               r_seq;
    logic [2:0]         r_j;
    logic [2:0]         r_i;
    logic [4:0]         r_k;
    logic signed [47:0] r_sacc;
    logic signed [39:0] r_coef [6];
    logic [45:0]        r_den;

    logic signed [18:0] w_sb;
    logic signed [66:0] w_sprod;
    logic signed [63:0] w_srnd;
    logic signed [15:0] w_scoef;
    logic signed [47:0] w_snext;

    bkw_pkg::t_kern     w_kp;
    logic               w_en;

    logic [12:0]        r_vld;
    logic signed [55:0] r_acc [13];
    logic signed [18:0] r_u   [12];
    logic signed [18:0] r_qmu [12];
    logic signed [18:0] r_opu [12];

    logic signed [18:0] w_b    [1:12];
    logic signed [74:0] w_prod [1:12];
    logic signed [63:0] w_rnd  [1:12];
    logic signed [55:0] w_add  [1:12];
    logic signed [55:0] w_nacc [1:12];

    logic signed [18:0] w_pos;
    logic [55:0]        w_mag;
    logic [27:0]        w_sabs;

    logic               r_p1_vld;
    logic [55:0]        r_p1_hi;
    logic [55:0]        r_p1_lo;
    logic               r_p1_neg;
    logic               r_p2_vld;
    logic [83:0]        r_p2_sum;
    logic               r_p2_neg;

    bkw_pkg::t_div_tag  w_tag_in;
    bkw_pkg::t_div_tag  w_tag_out;
    logic               w_div_vld;
    logic [47:0]        w_quo;
    logic [45:0]        w_rem;

    logic [48:0]        w_qt;
    logic [48:0]        w_lim;
    logic               w_sat;
    logic [48:0]        w_fin;

    logic               r_out_vld;
    logic signed [47:0] r_out_w;
    logic               r_out_sat;

    // configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == RegKernel) ? {28'd0, r_sel} : {15'd0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
            r_q   <= 17'(bkw_pkg::One);
        end else if (w_wr) begin
            if (paddr[2] == RegQ) begin
                r_q <= pwdata[16:0];
            end else begin
                r_sel <= pwdata[3:0];
            end
        end
    end

    // coefficient and denominator sequencer
    assign w_kp    = bkw_pkg::kern_info(r_sel);
    assign w_sb    = (r_seq == SEQ_COEF) ? $signed({2'b00, r_q})
                                         : $signed({1'b0, {1'b0, r_q} + 18'(bkw_pkg::One)});
    assign w_sprod = r_sacc * w_sb;
    assign w_srnd  = bkw_pkg::fx_rnd({{13{w_sprod[66]}}, w_sprod});
    assign w_scoef = bkw_pkg::coef(r_sel, r_j, r_i);
    assign w_snext = (r_seq == SEQ_COEF)
                   ? w_srnd[47:0] + {{16{w_scoef[15]}}, w_scoef, 16'd0}
                   : w_srnd[47:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_wr) begin
            r_seq  <= SEQ_COEF;
            r_j    <= '0;
            r_i    <= 3'd6;
            r_k    <= '0;
            r_sacc <= '0;
        end else begin
            case (r_seq)
                SEQ_COEF: begin
                    if (r_i == 3'd0) begin
                        r_coef[r_j] <= w_snext[39:0];
                        r_i         <= 3'd6;
                        if (r_j == 3'd5) begin
                            r_seq  <= SEQ_DEN;
                            r_k    <= '0;
                            r_sacc <= 48'(bkw_pkg::One);
                        end else begin
                            r_j    <= r_j + 3'd1;
                            r_sacc <= '0;
                        end
                    end else begin
                        r_i    <= r_i - 3'd1;
                        r_sacc <= w_snext;
                    end
                end
                SEQ_DEN: begin
                    if (r_k == w_kp.den_pow) begin
                        r_den <= r_sacc[45:0];
                        r_seq <= SEQ_DONE;
                    end else begin
                        r_k    <= r_k + 5'd1;
                        r_sacc <= w_snext;
                    end
                end
                SEQ_DONE: r_seq <= SEQ_DONE;
                default:  r_seq <= SEQ_COEF;
            endcase
        end
    end

    // pipeline control: the whole pipe holds while the output item waits
    assign w_en    = !(r_out_vld && !i_ready);
    assign o_ready = w_en && (r_seq == SEQ_DONE);

    assign w_pos = {i_position[17], i_position};

    always_comb begin
        for (int s = 1; s <= 12; s++) begin
            if (s <= 5) begin
                w_b[s]   = r_u[s - 1];
                w_add[s] = {{16{r_coef[3'(5 - s)][39]}}, r_coef[3'(5 - s)]};
            end else if (s <= 8) begin
                w_b[s]   = (2'(s - 6) < w_kp.qu_pow) ? r_qmu[s - 1] : 19'(bkw_pkg::One);
                w_add[s] = '0;
            end else begin
                w_b[s]   = (3'(s - 9) < w_kp.up_pow) ? r_opu[s - 1] : 19'(bkw_pkg::One);
                w_add[s] = '0;
            end
            w_prod[s] = r_acc[s - 1] * w_b[s];
            w_rnd[s]  = bkw_pkg::fx_rnd({{5{w_prod[s][74]}}, w_prod[s]});
            w_nacc[s] = w_rnd[s][55:0] + w_add[s];
        end
    end

    assign w_mag  = r_acc[12][55] ? 56'(-r_acc[12]) : 56'(r_acc[12]);
    assign w_sabs = w_kp.factor[28] ? 28'(-w_kp.factor) : w_kp.factor[27:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[11:0], i_valid & o_ready};
            r_p1_vld  <= r_vld[12];
            r_p2_vld  <= r_p1_vld;
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc[0] <= {{16{r_coef[5][39]}}, r_coef[5]};
            r_u[0]   <= w_pos;
            r_qmu[0] <= $signed({2'b00, r_q}) - w_pos;
            r_opu[0] <= 19'(bkw_pkg::One) + w_pos;
            for (int s = 1; s <= 12; s++) begin
                r_acc[s] <= w_nacc[s];
            end
            for (int s = 1; s < 12; s++) begin
                r_u[s]   <= r_u[s - 1];
                r_qmu[s] <= r_qmu[s - 1];
                r_opu[s] <= r_opu[s - 1];
            end
            r_p1_hi  <= w_mag[55:28] * w_sabs;
            r_p1_lo  <= w_mag[27:0] * w_sabs;
            r_p1_neg <= w_kp.factor[28] ^ r_acc[12][55];
            r_p2_sum <= {r_p1_hi, 28'd0} + {28'd0, r_p1_lo};
            r_p2_neg <= r_p1_neg;
        end
    end

    assign w_tag_in.neg  = r_p2_neg;
    assign w_tag_in.over = r_p2_sum[83:32] >= {6'd0, r_den};

    bkw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p2_vld),
        .i_rem   (r_p2_sum[77:32]),
        .i_num   ({r_p2_sum[31:0], 16'd0}),
        .i_den   (r_den),
        .i_tag   (w_tag_in),
        .o_valid (w_div_vld),
        .o_quo   (w_quo),
        .o_rem   (w_rem),
        .o_tag   (w_tag_out)
    );

    // round, clamp and apply sign
    assign w_qt  = {1'b0, w_quo} + 49'({w_rem, 1'b0} >= {1'b0, r_den});
    assign w_lim = w_tag_out.neg ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
    assign w_sat = w_tag_out.over || (w_qt > w_lim);
    assign w_fin = w_sat ? w_lim : w_qt;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_w   <= w_tag_out.neg ? -$signed(w_fin[47:0]) : $signed(w_fin[47:0]);
            r_out_sat <= w_sat;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_weight    = r_out_w;
    assign o_saturated = r_out_sat;

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_weight == SatMax || o_weight == SatMin))
        else $error("saturated item without clamped weight");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SEQ_DONE) |-> !o_ready)
        else $error("item accepted while coefficients are recomputed");

    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (r_seq == SEQ_COEF && r_j == 3'd0))
        else $error("register write did not restart the sequencer");

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for boundary_kernel_weight_eval_top: streams positions
// through the kernel evaluator across kernel and boundary settings, predicts each weight.
// Depends on the RTL top level only.
`timescale 1ns / 1ps

module testbench;

    localparam logic [2:0] KernelSelAddr = 3'd0;
    localparam logic [2:0] BoundaryQAddr = 3'd4;
    localparam int KernelUsed  = 10;
    localparam int KernelCodes = 16;
    localparam logic [16:0] QOne = 17'd65536;
    localparam logic [16:0] QMax = 17'h1FFFF;
    localparam int Latency = 64;
    localparam int CycleLimit = 400000;

    typedef struct {
        logic signed [47:0] weight;
        logic               saturated;
    } t_weight;

    localparam longint KFactor [KernelUsed] = '{2, 6, 60, 60, -420, 420, -840, 5040,
                                                -720720, 147026880};
    localparam int KQuPow  [KernelUsed] = '{0, 0, 1, 1, 1, 1, 1, 1, 2, 3};
    localparam int KUpPow  [KernelUsed] = '{0, 1, 2, 2, 2, 2, 2, 2, 3, 4};
    localparam int KDenPow [KernelUsed] = '{3, 4, 6, 8, 8, 10, 10, 10, 14, 18};
    localparam int KCoef [KernelUsed][6][7] = '{
        '{'{2,-2,2,0,0,0,0}, '{3,-3,0,0,0,0,0}, '{0,0,0,0,0,0,0},
          '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{1,-2,3,0,0,0,0}, '{2,-4,0,0,0,0,0}, '{0,0,0,0,0,0,0},
          '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{1,-2,2,0,0,0,0}, '{2,-3,0,0,0,0,0}, '{0,0,0,0,0,0,0},
          '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{3,-16,39,-30,10,0,0}, '{14,-63,84,-35,0,0,0}, '{14,-56,28,0,0,0,0},
          '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{2,-9,12,-5,0,0,0}, '{11,-26,19,0,0,0,0}, '{12,-16,0,0,0,0,0},
          '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{1,-10,45,-84,77,-30,5}, '{8,-70,216,-280,152,-30,0},
          '{18,-144,300,-240,54,0,0}, '{12,-90,120,-30,0,0,0},
          '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{4,-35,108,-140,76,-15,0}, '{37,-212,444,-344,97,0,0},
          '{90,-381,480,-183,0,0,0}, '{63,-210,105,0,0,0,0},
          '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{3,-24,50,-40,9,0,0}, '{30,-127,160,-61,0,0,0},
          '{77,-182,119,0,0,0,0}, '{56,-70,0,0,0,0,0},
          '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{6,-60,175,-210,105,-16,0}, '{78,-478,903,-672,157,0,0},
          '{315,-1200,1407,-510,0,0,0}, '{495,-1122,671,0,0,0,0},
          '{264,-308,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
        '{'{10,-120,459,-768,612,-216,25}, '{160,-1293,3420,-3912,1944,-321,0},
          '{884,-4836,8658,-6240,1482,0,0}, '{2184,-7878,8892,-3146,0,0,0},
          '{2470,-5460,3120,0,0,0,0}, '{1040,-1170,0,0,0,0,0}}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [17:0] i_position;
    logic               o_valid;
    logic               i_ready;
    logic signed [47:0] o_weight;
    logic               o_saturated;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logic [3:0]  cfg_kernel;
    logic [16:0] cfg_q;
    t_weight     pending_weights[$];
    int          fail_count;
    int          items_sent;
    int          results_seen;
    int          saturated_seen;
    int          cycle_count;
    bit          idle_on;

    boundary_kernel_weight_eval_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] round_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b);
        logic [127:0] p;
        logic [127:0] r;
        logic         neg;
        neg = a[63] ^ b[63];
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p + (128'd1 << 15);
        r = p >> 16;
        if (r > (128'd1 << 62)) r = 128'd1 << 62;
        return neg ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    function automatic t_weight kernel_weight(input logic [3:0] sel, input logic [16:0] qv,
                                              input logic signed [17:0] pos);
        t_weight            res;
        longint             one;
        longint             q;
        longint             u;
        longint             acc;
        longint             coefs[6];
        longint             factor;
        longint             d;
        int                 qu_pow;
        int                 up_pow;
        int                 den_pow;
        logic               neg;
        logic               over;
        logic [127:0]       num;
        logic [159:0]       quot;
        logic [159:0]       rem;
        logic [159:0]       den;
        logic [159:0]       cap;
        one = 64'sd65536;
        q = longint'({1'b0, qv});
        u = longint'(pos);
        factor = 0;
        qu_pow = 0;
        up_pow = 0;
        den_pow = 0;
        for (int j = 0; j < 6; j++) begin
            acc = 0;
            for (int i = 6; i >= 0; i--) begin
                acc = round_product(acc, q);
                if (sel < KernelUsed) acc = acc + longint'(KCoef[sel][j][i]) * one;
            end
            coefs[j] = acc;
        end
        if (sel < KernelUsed) begin
            factor = KFactor[sel];
            qu_pow = KQuPow[sel];
            up_pow = KUpPow[sel];
            den_pow = KDenPow[sel];
        end
        acc = 0;
        for (int j = 5; j >= 0; j--) acc = round_product(acc, u) + coefs[j];
        for (int i = 0; i < qu_pow; i++) acc = round_product(acc, q - u);
        for (int i = 0; i < up_pow; i++) acc = round_product(acc, one + u);
        d = one;
        for (int i = 0; i < den_pow; i++) d = round_product(d, one + q);
        neg = (factor < 0) != (acc < 0);
        num = {64'd0, magnitude(factor)} * {64'd0, magnitude(acc)};
        den = (d == 0) ? 160'd1 : {96'd0, magnitude(d)};
        quot = {16'd0, num, 16'd0} / den;
        rem = {16'd0, num, 16'd0} % den;
        over = quot >= (160'd1 << 50);
        if (!over && rem >= den - rem) quot = quot + 1;
        cap = neg ? (160'd1 << 47) : ((160'd1 << 47) - 1);
        res.saturated = over || quot > cap;
        if (res.saturated) quot = cap;
        res.weight = neg ? -$signed(quot[47:0]) : $signed(quot[47:0]);
        return res;
    endfunction

    task automatic idle_burst();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic send_position(input logic signed [17:0] pos);
        @(negedge i_clk);
        idle_burst();
        i_valid <= 1'b1;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        pending_weights.push_back(kernel_weight(cfg_kernel, cfg_q, pos));
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_weights.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        drain();
        repeat (Latency + 4) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == KernelSelAddr) cfg_kernel = data[3:0];
        else cfg_q = data[16:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic signed [17:0] random_position();
        case ($urandom_range(0, 9))
            0: return $signed(18'($urandom));
            1: return 18'sh20000;
            2: return 18'sh1FFFF;
            3: return 18'sd65536;
            4: return -18'sd65536;
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic [16:0] random_q();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return QOne;
            2: return QMax;
            3: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("boundary_kernel_weight_eval_top verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_weight want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_saturated) saturated_seen++;
            if (pending_weights.size() == 0) begin
                $error("unexpected result: weight %0d saturated %0b", o_weight, o_saturated);
                fail_count++;
            end else begin
                want = pending_weights.pop_front();
                if (o_weight !== want.weight) begin
                    $error("weight: expected %0d, got %0d", want.weight, o_weight);
                    fail_count++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b", want.saturated, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_position_extremes();
        send_position(-18'sd65536);
        send_position(18'sd0);
        send_position(18'sd65536);
        send_position(18'sh20000);
        send_position(18'sh1FFFF);
        send_position(18'sd1);
        send_position(-18'sd1);
    endtask

    task automatic test_every_kernel();
        for (int k = 0; k < KernelCodes; k++) begin
            write_reg(KernelSelAddr, 32'(k));
            write_reg(BoundaryQAddr, (k % 3 == 0) ? 32'd0 : (k % 3 == 1) ? 32'(QMax) : 32'd32768);
            send_position((k % 2 == 0) ? 18'sh20000 : 18'sd40000);
        end
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 36; phase++) begin
            write_reg(KernelSelAddr, ($urandom_range(0, 7) == 0) ?
                      32'($urandom_range(KernelUsed, KernelCodes - 1)) :
                      32'($urandom_range(0, KernelUsed - 1)));
            write_reg(BoundaryQAddr, {15'($urandom), random_q()});
            for (int n = 0; n < 48; n++) begin
                if (phase == 5 && n == 24) drain();
                send_position(random_position());
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        write_reg(KernelSelAddr, 32'd9);
        write_reg(BoundaryQAddr, 32'(QOne));
        for (int n = 0; n < 120; n++) send_position(random_position());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_position = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_kernel = '0;
        cfg_q = QOne;
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        saturated_seen = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_position_extremes();
        test_every_kernel();
        test_random_settings();
        test_back_to_back();
        drain();
        repeat (Latency + 16) @(posedge i_clk);
        $display("covered all 16 kernel codes, boundary q from 0 to full scale, positions at both");
        $display("ends: %0d items, %0d results, %0d saturated", items_sent, results_seen,
                 saturated_seen);
        if (fail_count == 0 && pending_weights.size() == 0) begin
            $display("boundary_kernel_weight_eval_top verification clean");
        end else begin
            $display("boundary_kernel_weight_eval_top verification failed");
        end
        $finish;
    end

endmodule
